/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

/* hdl/dpr_pkg.sv */
`timescale 1ns / 1ps
package dpr_pkg;

  // Register indexes on the config port
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_NUMER  = 2'd2,
    REG_FOCAL  = 2'd3
  } reg_idx_e;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned QBITS     = 24;   // quotient bits per divider
  localparam int unsigned DEN_W     = 39;   // disparity (15b) times focal (24b)

  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [31:0] NUMER_RST  = 32'd1117837;
  localparam logic [23:0] FOCAL_RST  = 24'd150060;

  localparam logic [23:0] DEPTH_MAX  = 24'd4194303;
  localparam logic [23:0] XY_POS_MAX = 24'h7FFFFF;
  localparam logic [23:0] XY_NEG_MAX = 24'h800000;

  // Partial state of one restoring divider
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QBITS-1:0] low;   // dividend bits not yet shifted in
    logic [QBITS-1:0] quo;
    logic             ovf;   // quotient does not fit in QBITS
  } div_t;

  // Payload of one divider pipeline stage
  typedef struct packed {
    logic             pos;
    logic             neg_x;
    logic             neg_y;
    logic [DEN_W-1:0] den_l;
    logic [DEN_W-1:0] den_d;
    div_t             dx;
    div_t             dy;
    div_t             dd;
  } dstg_t;

  // One quotient bit: shift in the next dividend bit, compare, subtract
  function automatic div_t div_step(div_t a, logic [DEN_W-1:0] den);
    div_t       r;
    logic [DEN_W:0] t;
    logic       qb;
    t  = {a.rem, a.low[QBITS-1]};
    qb = (t >= {1'b0, den});
    if (qb) begin
      t = t - {1'b0, den};
    end
    r.rem = t[DEN_W-1:0];
    r.low = {a.low[QBITS-2:0], 1'b0};
    r.quo = {a.quo[QBITS-2:0], qb};
    r.ovf = a.ovf;
    return r;
  endfunction

  // One pipeline stage: all three dividers advance by one quotient bit
  function automatic dstg_t dstg_step(dstg_t a);
    dstg_t r;
    r    = a;
    r.dx = div_step(a.dx, a.den_l);
    r.dy = div_step(a.dy, a.den_l);
    r.dd = div_step(a.dd, a.den_d);
    return r;
  endfunction

  // Center of a frame dimension, clamped to the largest frame
  function automatic logic [11:0] centre_of(logic [12:0] dim);
    logic [12:0] c;
    c = (dim > 13'(MAX_DIM)) ? 13'(MAX_DIM) : dim;
    return c[12:1];
  endfunction

endpackage

/* hdl/dpr_if.sv */
`timescale 1ns / 1ps
// Pixel in: row, column, disparity
interface dpr_pix_if;
  logic               valid;
  logic               ready;
  logic        [11:0] pixel_row;
  logic        [11:0] pixel_col;
  logic signed [15:0] disparity;
  modport source (output valid, pixel_row, pixel_col, disparity, input ready);
  modport sink   (input valid, pixel_row, pixel_col, disparity, output ready);
endinterface

// Point out: lateral offsets, depth, valid flag
interface dpr_pt_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x_mm;
  logic signed [23:0] point_y_mm;
  logic        [21:0] depth_mm;
  logic               point_valid;
  modport source (output valid, point_x_mm, point_y_mm, depth_mm, point_valid,
                  input ready);
  modport sink   (input valid, point_x_mm, point_y_mm, depth_mm, point_valid,
                  output ready);
endinterface

/* hdl/disparity_to_point_reprojection.sv */
`timescale 1ns / 1ps
// Pipeline: 3 setup stages, 24 one-bit divider stages, one output register.
// Throughput: one item per cycle unless the output is held; the three dividers are fully pipelined.
// Backpressure stalls the whole pipeline at once; nothing is dropped.
// Reset (async, active low) clears all valid bits and loads register defaults.
`include "assert_macros.svh"
module disparity_to_point_reprojection (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  dpr_pix_if.sink       pix_i,
  dpr_pt_if.source      pt_o
);

  localparam int unsigned ND = dpr_pkg::QBITS;

  // Config registers
  logic [12:0] width_q, height_q;
  logic [31:0] numer_q;
  logic [23:0] focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dpr_pkg::WIDTH_RST;
      height_q <= dpr_pkg::HEIGHT_RST;
      numer_q  <= dpr_pkg::NUMER_RST;
      focal_q  <= dpr_pkg::FOCAL_RST;
    end else if (cfg_we_i) begin
      unique case (dpr_pkg::reg_idx_e'(cfg_idx_i))
        dpr_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i[12:0];
        dpr_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[12:0];
        dpr_pkg::REG_NUMER:  numer_q  <= cfg_wdata_i;
        dpr_pkg::REG_FOCAL:  focal_q  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output is held
  logic adv;
  logic out_vld_q;
  assign adv         = !out_vld_q || pt_o.ready;
  assign pix_i.ready = adv;

  logic        s1_vld_q, s2_vld_q;
  logic [ND:0] dv_q;

  // Stage 1: offsets from the frame center, sign split
  logic        s1_pos_q, s1_negx_q, s1_negy_q;
  logic [14:0] s1_d_q;
  logic [11:0] s1_magx_q, s1_magy_q;
  logic signed [13:0] offx, offy;

  assign offx = $signed({2'b00, pix_i.pixel_col})
              - $signed({2'b00, dpr_pkg::centre_of(width_q)});
  assign offy = $signed({2'b00, pix_i.pixel_row})
              - $signed({2'b00, dpr_pkg::centre_of(height_q)});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pos_q  <= (pix_i.disparity > 16'sd0);
      s1_d_q    <= pix_i.disparity[14:0];
      s1_negx_q <= offx[13];
      s1_negy_q <= offy[13];
      s1_magx_q <= offx[13] ? 12'(-offx) : offx[11:0];
      s1_magy_q <= offy[13] ? 12'(-offy) : offy[11:0];
    end
  end

  // Stage 2: numerator and denominator products
  logic        s2_pos_q, s2_negx_q, s2_negy_q;
  logic [14:0] s2_d_q;
  logic [38:0] s2_den_q;
  logic [43:0] s2_px_q, s2_py_q;
  logic [23:0] focal_eff;

  assign focal_eff = (focal_q == 24'd0) ? 24'd1 : focal_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pos_q  <= s1_pos_q;
      s2_negx_q <= s1_negx_q;
      s2_negy_q <= s1_negy_q;
      s2_d_q    <= s1_d_q;
      s2_den_q  <= 39'(s1_d_q) * 39'(focal_eff);
      s2_px_q   <= 44'(s1_magx_q) * 44'(numer_q);
      s2_py_q   <= 44'(s1_magy_q) * 44'(numer_q);
    end
  end

  // Stage 3: divider setup; top dividend bits form the first remainder
  dpr_pkg::dstg_t dp_q [0:ND];
  dpr_pkg::dstg_t init;
  logic [51:0] numx, numy;

  assign numx = {s2_px_q, 8'd0};
  assign numy = {s2_py_q, 8'd0};

  always_comb begin
    init.pos    = s2_pos_q;
    init.neg_x  = s2_negx_q;
    init.neg_y  = s2_negy_q;
    init.den_l  = s2_den_q;
    init.den_d  = 39'(s2_d_q);
    init.dx.rem = 39'(numx[51:24]);
    init.dx.low = numx[23:0];
    init.dx.quo = '0;
    init.dx.ovf = (39'(numx[51:24]) >= s2_den_q);
    init.dy.rem = 39'(numy[51:24]);
    init.dy.low = numy[23:0];
    init.dy.quo = '0;
    init.dy.ovf = (39'(numy[51:24]) >= s2_den_q);
    init.dd.rem = 39'(numer_q[31:24]);
    init.dd.low = numer_q[23:0];
    init.dd.quo = '0;
    init.dd.ovf = (15'(numer_q[31:24]) >= s2_d_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_q[0] <= init;
    end
  end

  // Divider stages: one quotient bit per stage for all three dividers
  for (genvar i = 0; i < ND; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dp_q[i+1] <= dpr_pkg::dstg_step(dp_q[i]);
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      dv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pix_i.valid;
      s2_vld_q  <= s1_vld_q;
      dv_q      <= {dv_q[ND-1:0], s2_vld_q};
      out_vld_q <= dv_q[ND];
    end
  end

  // Saturation and sign restore
  dpr_pkg::dstg_t fin;
  logic [23:0] x_d, y_d, dep_d;
  logic        bigx, bigy, bigd;

  assign fin  = dp_q[ND];
  assign bigx = fin.dx.ovf || fin.dx.quo[23];
  assign bigy = fin.dy.ovf || fin.dy.quo[23];
  assign bigd = fin.dd.ovf || (fin.dd.quo > dpr_pkg::DEPTH_MAX);

  always_comb begin
    if (!fin.pos) begin
      x_d   = '0;
      y_d   = '0;
      dep_d = '0;
    end else begin
      if (fin.neg_x) x_d = bigx ? dpr_pkg::XY_NEG_MAX : 24'(-fin.dx.quo);
      else           x_d = bigx ? dpr_pkg::XY_POS_MAX : fin.dx.quo;
      if (fin.neg_y) y_d = bigy ? dpr_pkg::XY_NEG_MAX : 24'(-fin.dy.quo);
      else           y_d = bigy ? dpr_pkg::XY_POS_MAX : fin.dy.quo;
      dep_d = bigd ? dpr_pkg::DEPTH_MAX : fin.dd.quo;
    end
  end

  // Output register
  logic [23:0] x_q, y_q;
  logic [21:0] dep_q;
  logic        pv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q   <= x_d;
      y_q   <= y_d;
      dep_q <= dep_d[21:0];
      pv_q  <= fin.pos;
    end
  end

  assign pt_o.valid       = out_vld_q;
  assign pt_o.point_x_mm  = x_q;
  assign pt_o.point_y_mm  = y_q;
  assign pt_o.depth_mm    = dep_q;
  assign pt_o.point_valid = pv_q;

  // Checks
  `ASSERT_ALWAYS(a_invalid_zero, clk_i, rst_ni, !(pt_o.valid && !pt_o.point_valid) || (pt_o.point_x_mm == 24'sd0 && pt_o.point_y_mm == 24'sd0 && pt_o.depth_mm == 22'd0), "invalid point not all zero")
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, pix_i.valid && pix_i.ready, s1_vld_q, "accepted item missing in stage 1")
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !adv, $stable(dv_q) && $stable(s1_vld_q) && $stable(s2_vld_q), "pipeline moved while stalled")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY    = 28;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_LEN   = 200;

  typedef struct packed {
    logic [11:0]        row;
    logic [11:0]        col;
    logic signed [15:0] disp;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [21:0]        depth;
    logic               ok;
  } point_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  dpr_pkg::reg_idx_e cfg_idx_i = dpr_pkg::REG_WIDTH;
  logic [31:0]       cfg_wdata_i = '0;

  dpr_pix_if pix ();
  dpr_pt_if  pt ();

  disparity_to_point_reprojection dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pix_i(pix.sink), .pt_o(pt.source)
  );

  always #6 clk_i = ~clk_i;

  // Camera setup as seen by the predictor
  logic [12:0] cam_width  = dpr_pkg::WIDTH_RST;
  logic [12:0] cam_height = dpr_pkg::HEIGHT_RST;
  logic [31:0] cam_numer  = dpr_pkg::NUMER_RST;
  logic [23:0] cam_focal  = dpr_pkg::FOCAL_RST;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;
  int     n_errors = 0;
  int     n_points = 0;
  int     n_valid_points = 0;
  int     quiet_cycles = 0;
  bit     stim_done = 1'b0;

  // Offset times depth over focal, toward zero, saturated to 24 bits
  function automatic logic [23:0] lateral_mm(int offs, longint unsigned disp,
                                             longint unsigned focal);
    longint unsigned mag, q;
    mag = (offs < 0) ? -offs : offs;
    q = (mag * cam_numer * 256) / (disp * focal);
    if (offs < 0) return (q >= 64'h800000) ? dpr_pkg::XY_NEG_MAX : 24'(-longint'(q));
    return (q > 64'h7FFFFF) ? dpr_pkg::XY_POS_MAX : q[23:0];
  endfunction

  function automatic point_t project_pixel(pixel_t p);
    point_t r;
    longint unsigned focal, dep;
    int cc, cr;
    r = '0;
    if (p.disp <= 0) return r;
    focal = (cam_focal == 0) ? 1 : cam_focal;
    dep = cam_numer / longint'(p.disp);
    if (dep > 4194303) dep = 4194303;
    cc = ((cam_width > 4096) ? 4096 : cam_width) / 2;
    cr = ((cam_height > 4096) ? 4096 : cam_height) / 2;
    r.x = lateral_mm(int'(p.col) - cc, longint'(p.disp), focal);
    r.y = lateral_mm(int'(p.row) - cr, longint'(p.disp), focal);
    r.depth = dep[21:0];
    r.ok = 1'b1;
    return r;
  endfunction

  // Pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.pixel_row <= '0;
      pix.pixel_col <= '0;
      pix.disparity <= '0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_points.insert(expected_points.size(),
                               project_pixel({pix.pixel_row, pix.pixel_col,
                                              pix.disparity}));
      end
      if (!pix.valid || pix.ready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_t p;
          p = pending_pixels.pop_front();
          pix.valid <= 1'b1;
          pix.pixel_row <= p.row;
          pix.pixel_col <= p.col;
          pix.disparity <= p.disp;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Point receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (hold_req && hold_cnt == 0) hold_cnt <= HOLD_LEN;
      else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
      pt.ready <= (hold_cnt <= 1) && !(hold_req && hold_cnt == 0) &&
                  ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Point monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni && pt.valid && pt.ready) begin
      point_t e;
      if (expected_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d", pt.point_x_mm, pt.point_y_mm);
        n_errors++;
      end else begin
        e = expected_points.pop_front();
        n_points++;
        if (e.ok) n_valid_points++;
        if (pt.point_x_mm !== e.x) begin
          $error("point_x_mm exp %0d got %0d", e.x, pt.point_x_mm); n_errors++;
        end
        if (pt.point_y_mm !== e.y) begin
          $error("point_y_mm exp %0d got %0d", e.y, pt.point_y_mm); n_errors++;
        end
        if (pt.depth_mm !== e.depth) begin
          $error("depth_mm exp %0d got %0d", e.depth, pt.depth_mm); n_errors++;
        end
        if (pt.point_valid !== e.ok) begin
          $error("point_valid exp %0b got %0b", e.ok, pt.point_valid); n_errors++;
        end
      end
    end
  end

  // Watchdog on accepted items
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (pt.valid && pt.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress");
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(dpr_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dpr_pkg::REG_WIDTH:  cam_width  = val[12:0];
      dpr_pkg::REG_HEIGHT: cam_height = val[12:0];
      dpr_pkg::REG_NUMER:  cam_numer  = val;
      dpr_pkg::REG_FOCAL:  cam_focal  = val[23:0];
    endcase
  endtask

  task automatic drain_pipe();
    while (pending_pixels.size() > 0 || pix.valid || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic add_pixel(int r, int c, int d);
    pixel_t p;
    p.row = 12'(r); p.col = 12'(c); p.disp = 16'(d);
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  // Mostly positive disparities, small ones often to reach saturation
  task automatic add_random(int n);
    int d;
    repeat (n) begin
      case ($urandom_range(9))
        0:       d = -$urandom_range(32768);
        1:       d = 0;
        2, 3:    d = $urandom_range(1, 16);
        default: d = $urandom_range(1, 32767);
      endcase
      add_pixel($urandom_range(4095), $urandom_range(4095), d);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and special cases at reset setup
    add_pixel(0, 0, 1);
    add_pixel(4095, 4095, 1);
    add_pixel(240, 320, 16);
    add_pixel(4095, 0, 32767);
    add_pixel(0, 4095, 0);
    add_pixel(100, 100, -1);
    add_pixel(100, 100, -32768);
    add_pixel(2730, 1365, 21845);
    add_pixel(1365, 2730, 10922);
    drain_pipe();
    // Zero numerator and zero focal length
    write_reg(dpr_pkg::REG_NUMER, 0);
    write_reg(dpr_pkg::REG_FOCAL, 0);
    add_pixel(0, 4095, 5);
    add_pixel(4095, 0, 32767);
    drain_pipe();
    // Oversized and zero frame, largest numerator and focal
    write_reg(dpr_pkg::REG_WIDTH, 13'h1FFF);
    write_reg(dpr_pkg::REG_HEIGHT, 0);
    write_reg(dpr_pkg::REG_NUMER, 32'hFFFFFFFF);
    write_reg(dpr_pkg::REG_FOCAL, 24'hFFFFFF);
    add_pixel(0, 0, 1);
    add_pixel(4095, 4095, 1);
    add_pixel(4095, 2048, 32767);
    add_pixel(17, 4095, 300);
    drain_pipe();

    // Random phases under varying setup and flow control
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(dpr_pkg::REG_WIDTH, $urandom_range(8191));
      write_reg(dpr_pkg::REG_HEIGHT, $urandom_range(8191));
      write_reg(dpr_pkg::REG_NUMER, (ph == 1) ? 1 : $urandom);
      write_reg(dpr_pkg::REG_FOCAL, (ph == 2) ? 1 : $urandom_range(24'hFFFFFF));
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 75 : 15) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 75 : 15) : 0;
      add_random(300);
      if (ph == 4) begin
        repeat (20) @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      drain_pipe();
    end
    write_reg(dpr_pkg::REG_WIDTH, dpr_pkg::WIDTH_RST);
    write_reg(dpr_pkg::REG_HEIGHT, dpr_pkg::HEIGHT_RST);
    write_reg(dpr_pkg::REG_NUMER, dpr_pkg::NUMER_RST);
    write_reg(dpr_pkg::REG_FOCAL, dpr_pkg::FOCAL_RST);
    add_random(20);
    drain_pipe();

    $display("checked %0d points (%0d with positive disparity) over 9 setups",
             n_points, n_valid_points);
    if (n_errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
